[design/r2y420_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y420_pkg
// Shared types, constants and helpers for the RGB to YUV 4:2:0 packer.
// ----------------------------------------------------------------------------
package r2y420_pkg;

    // Port and state widths
    localparam int SAMPLE_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 25;
    localparam int LUMA_W    = 24;
    localparam int CHROMA_W  = 22;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Defaults
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    // Depth of the queue between front and back
    localparam int JOB_QUEUE_DEPTH = 4;

    // BT.601 integer coefficients
    localparam int SUM_W = 18;
    localparam logic signed [SUM_W-1:0] K_Y_R   = 18'sd66;
    localparam logic signed [SUM_W-1:0] K_Y_G   = 18'sd129;
    localparam logic signed [SUM_W-1:0] K_Y_B   = 18'sd25;
    localparam logic signed [SUM_W-1:0] K_U_R   = -18'sd38;
    localparam logic signed [SUM_W-1:0] K_U_G   = -18'sd74;
    localparam logic signed [SUM_W-1:0] K_U_B   = 18'sd112;
    localparam logic signed [SUM_W-1:0] K_V_R   = 18'sd112;
    localparam logic signed [SUM_W-1:0] K_V_G   = -18'sd94;
    localparam logic signed [SUM_W-1:0] K_V_B   = -18'sd18;
    localparam logic signed [SUM_W-1:0] K_ROUND = 18'sd128;
    localparam logic [BYTE_W-1:0] Y_BIAS      = 8'd16;
    localparam logic [BYTE_W-1:0] CHROMA_BIAS = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_LAYOUT       = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        LAYOUT_I420 = 2'd0,
        LAYOUT_YV12 = 2'd1,
        LAYOUT_NV12 = 2'd2,
        LAYOUT_NV21 = 2'd3
    } layout_t;

    // Byte being emitted for the current pixel
    typedef enum logic [1:0] {
        SEL_LUMA   = 2'd0,
        SEL_FIRST  = 2'd1,
        SEL_SECOND = 2'd2
    } byte_sel_t;

    // Chroma placement seen by the back end
    typedef struct packed {
        layout_t            layout;
        logic [ADDR_W-1:0]  low_base;   // W*H
        logic [ADDR_W-1:0]  high_base;  // W*H + W*H/4
    } chroma_cfg_t;

    // One classified pixel travelling from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]   y;
        logic [BYTE_W-1:0]   u;
        logic [BYTE_W-1:0]   v;
        logic [LUMA_W-1:0]   luma_addr;
        logic [CHROMA_W-1:0] chroma_idx;
        logic                chroma;
        logic                frame_end;
    } job_t;

    // Round down to even, then saturate to 2..limit (limit rounded down to even)
    function automatic logic [31:0] eff_size(input logic [CFG_W-1:0] raw,
                                             input int unsigned limit);
        logic [31:0] v;
        logic [31:0] lim;
        v   = 32'(raw) & 32'hFFFF_FFFE;
        lim = 32'(limit) & 32'hFFFF_FFFE;
        if (lim < 32'd2)
        begin
            lim = 32'd2;
        end
        if (v < 32'd2)
        begin
            v = 32'd2;
        end
        if (v > lim)
        begin
            v = lim;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] clamp_sample(
        input logic signed [SAMPLE_W-1:0] s);
        logic [BYTE_W-1:0] c;
        if (s < 0)
        begin
            c = '0;
        end
        else if (s > 16'sd255)
        begin
            c = 8'hFF;
        end
        else
        begin
            c = s[BYTE_W-1:0];
        end
        return c;
    endfunction

endpackage

[design/r2y420_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y420_cfg
// Configuration registers: effective frame size, plane bases and layout.
// ----------------------------------------------------------------------------
module r2y420_cfg #(
    parameter int MAX_WIDTH  = r2y420_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = r2y420_pkg::DEF_MAX_HEIGHT,
    parameter int DIMW_W     = $clog2(MAX_WIDTH + 1),
    parameter int DIMH_W     = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [r2y420_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [r2y420_pkg::CFG_W-1:0]          cfg_wdata,
    output logic                                  restart,
    output logic [DIMW_W-1:0]                     eff_width,
    output logic [DIMH_W-1:0]                     eff_height,
    output r2y420_pkg::chroma_cfg_t               chroma_cfg
);
    import r2y420_pkg::*;

    localparam int AREA_W = DIMW_W + DIMH_W;
    localparam logic [31:0] RST_W = eff_size(RESET_WIDTH, MAX_WIDTH);
    localparam logic [31:0] RST_H = eff_size(RESET_HEIGHT, MAX_HEIGHT);
    localparam logic [63:0] RST_AREA = 64'(RST_W) * 64'(RST_H);

    logic [DIMW_W-1:0] width_reg,  width_next;
    logic [DIMH_W-1:0] height_reg, height_next;
    logic [AREA_W-1:0] area_reg,   area_next;
    logic [AREA_W-1:0] hbase_reg,  hbase_next;
    layout_t           layout_reg, layout_next;

    logic [31:0] wr_w;
    logic [31:0] wr_h;

    always_comb
    begin
        wr_w        = eff_size(cfg_wdata, MAX_WIDTH);
        wr_h        = eff_size(cfg_wdata, MAX_HEIGHT);
        width_next  = width_reg;
        height_next = height_reg;
        layout_next = layout_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    width_next = wr_w[DIMW_W-1:0];
                    restart    = 1'b1;
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_next = wr_h[DIMH_W-1:0];
                    restart     = 1'b1;
                end
                CFG_LAYOUT:
                begin
                    layout_next = layout_t'(cfg_wdata[1:0]);
                    restart     = 1'b1;
                end
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
        area_next  = AREA_W'(width_next) * AREA_W'(height_next);
        hbase_next = area_next + (area_next >> 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_W[DIMW_W-1:0];
            height_reg <= RST_H[DIMH_W-1:0];
            area_reg   <= RST_AREA[AREA_W-1:0];
            hbase_reg  <= AREA_W'(RST_AREA + (RST_AREA >> 2));
            layout_reg <= LAYOUT_I420;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            area_reg   <= area_next;
            hbase_reg  <= hbase_next;
            layout_reg <= layout_next;
        end
    end

    assign eff_width            = width_reg;
    assign eff_height           = height_reg;
    assign chroma_cfg.layout    = layout_reg;
    assign chroma_cfg.low_base  = ADDR_W'(area_reg);
    assign chroma_cfg.high_base = ADDR_W'(hbase_reg);

endmodule

[design/r2y420_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y420_front
// Pixel intake: clamp, BT.601 conversion, raster position and job build.
// ----------------------------------------------------------------------------
module r2y420_front #(
    parameter int MAX_WIDTH  = r2y420_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = r2y420_pkg::DEF_MAX_HEIGHT,
    parameter int DIMW_W     = $clog2(MAX_WIDTH + 1),
    parameter int DIMH_W     = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [r2y420_pkg::SAMPLE_W-1:0] red_sample,
    input  logic signed [r2y420_pkg::SAMPLE_W-1:0] green_sample,
    input  logic signed [r2y420_pkg::SAMPLE_W-1:0] blue_sample,
    input  logic                                 restart,
    input  logic [DIMW_W-1:0]                    eff_width,
    input  logic [DIMH_W-1:0]                    eff_height,
    output logic                                 job_push,
    output r2y420_pkg::job_t                     job,
    input  logic                                 job_full
);
    import r2y420_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0]    col_reg,    col_next;
    logic [ROW_W-1:0]    row_reg,    row_next;
    logic [LUMA_W-1:0]   luma_reg,   luma_next;
    logic [CHROMA_W-1:0] chroma_reg, chroma_next;

    logic                    accept;
    logic [DIMW_W-1:0]       col_inc;
    logic [DIMH_W-1:0]       row_inc;
    logic                    col_end;
    logic                    row_end;
    logic                    frame_end;
    logic                    chroma;
    logic [BYTE_W-1:0]       r_c, g_c, b_c;
    logic signed [SUM_W-1:0] r_s, g_s, b_s;
    logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign job_push = accept;

    assign col_inc   = DIMW_W'(col_reg) + DIMW_W'(1);
    assign row_inc   = DIMH_W'(row_reg) + DIMH_W'(1);
    assign col_end   = col_inc >= eff_width;
    assign row_end   = row_inc >= eff_height;
    assign frame_end = col_end && row_end;
    assign chroma    = !row_reg[0] && !col_reg[0];

    // Colour conversion; bits [15:8] of the sum are the floored shift mod 256
    always_comb
    begin
        r_c   = clamp_sample(red_sample);
        g_c   = clamp_sample(green_sample);
        b_c   = clamp_sample(blue_sample);
        r_s   = $signed(SUM_W'(r_c));
        g_s   = $signed(SUM_W'(g_c));
        b_s   = $signed(SUM_W'(b_c));
        y_sum = K_Y_R * r_s + K_Y_G * g_s + K_Y_B * b_s + K_ROUND;
        u_sum = K_U_R * r_s + K_U_G * g_s + K_U_B * b_s + K_ROUND;
        v_sum = K_V_R * r_s + K_V_G * g_s + K_V_B * b_s + K_ROUND;

        job.y          = y_sum[15:8] + Y_BIAS;
        job.u          = u_sum[15:8] + CHROMA_BIAS;
        job.v          = v_sum[15:8] + CHROMA_BIAS;
        job.luma_addr  = luma_reg;
        job.chroma_idx = chroma_reg;
        job.chroma     = chroma;
        job.frame_end  = frame_end;
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        luma_next   = luma_reg;
        chroma_next = chroma_reg;
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            luma_next   = '0;
            chroma_next = '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                col_next    = '0;
                row_next    = '0;
                luma_next   = '0;
                chroma_next = '0;
            end
            else
            begin
                luma_next = luma_reg + LUMA_W'(1);
                if (chroma)
                begin
                    chroma_next = chroma_reg + CHROMA_W'(1);
                end
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_inc[ROW_W-1:0];
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            luma_reg   <= '0;
            chroma_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            luma_reg   <= luma_next;
            chroma_reg <= chroma_next;
        end
    end

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        DIMW_W'(col_reg) < eff_width && DIMH_W'(row_reg) < eff_height)
        else $error("raster position outside the frame");

endmodule

[design/r2y420_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y420_fifo
// Small register queue decoupling pixel intake from byte emission.
// ----------------------------------------------------------------------------
module r2y420_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

endmodule

[design/r2y420_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y420_back
// Byte sequencer: expands each job into its Y transfer and, for chroma pixels, its U and V transfers.
// ----------------------------------------------------------------------------
module r2y420_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  r2y420_pkg::job_t                  job_in,
    input  logic                              job_empty,
    output logic                              job_pop,
    input  r2y420_pkg::chroma_cfg_t           chroma_cfg,
    output logic                              empty,
    input  logic                              pop,
    output logic [r2y420_pkg::ADDR_W-1:0]     byte_address,
    output logic [r2y420_pkg::BYTE_W-1:0]     byte_value,
    output logic                              last_of_pixel,
    output logic                              frame_done
);
    import r2y420_pkg::*;

    job_t              job_reg,   job_next;
    logic              busy_reg,  busy_next;
    byte_sel_t         sel_reg,   sel_next;
    logic              ovld_reg,  ovld_next;
    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic [BYTE_W-1:0] val_reg,   val_next;
    logic              last_reg,  last_next;
    logic              done_reg,  done_next;

    logic              advance;
    logic              finishing;
    logic              load;
    logic [ADDR_W-1:0] idx;
    logic [ADDR_W-1:0] first_addr, second_addr;
    logic [BYTE_W-1:0] first_val,  second_val;

    assign advance = !ovld_reg || pop;

    // Chroma placement for the current job
    always_comb
    begin
        idx = ADDR_W'(job_reg.chroma_idx);
        unique case (chroma_cfg.layout)
            LAYOUT_I420:
            begin
                first_addr  = chroma_cfg.low_base + idx;
                second_addr = chroma_cfg.high_base + idx;
                first_val   = job_reg.u;
                second_val  = job_reg.v;
            end
            LAYOUT_YV12:
            begin
                first_addr  = chroma_cfg.high_base + idx;
                second_addr = chroma_cfg.low_base + idx;
                first_val   = job_reg.u;
                second_val  = job_reg.v;
            end
            LAYOUT_NV12:
            begin
                first_addr  = chroma_cfg.low_base + {idx[ADDR_W-2:0], 1'b0};
                second_addr = chroma_cfg.low_base + {idx[ADDR_W-2:0], 1'b1};
                first_val   = job_reg.u;
                second_val  = job_reg.v;
            end
            LAYOUT_NV21:
            begin
                first_addr  = chroma_cfg.low_base + {idx[ADDR_W-2:0], 1'b0};
                second_addr = chroma_cfg.low_base + {idx[ADDR_W-2:0], 1'b1};
                first_val   = job_reg.v;
                second_val  = job_reg.u;
            end
            default:
            begin
                first_addr  = '0;
                second_addr = '0;
                first_val   = '0;
                second_val  = '0;
            end
        endcase
    end

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        sel_next  = sel_reg;
        ovld_next = ovld_reg;
        addr_next = addr_reg;
        val_next  = val_reg;
        last_next = last_reg;
        done_next = done_reg;
        finishing = 1'b0;

        if (advance)
        begin
            ovld_next = busy_reg;
            if (busy_reg)
            begin
                unique case (sel_reg)
                    SEL_LUMA:
                    begin
                        addr_next = ADDR_W'(job_reg.luma_addr);
                        val_next  = job_reg.y;
                        last_next = !job_reg.chroma;
                        done_next = job_reg.frame_end && !job_reg.chroma;
                        if (job_reg.chroma)
                        begin
                            sel_next = SEL_FIRST;
                        end
                        else
                        begin
                            finishing = 1'b1;
                        end
                    end
                    SEL_FIRST:
                    begin
                        addr_next = first_addr;
                        val_next  = first_val;
                        last_next = 1'b0;
                        done_next = 1'b0;
                        sel_next  = SEL_SECOND;
                    end
                    SEL_SECOND:
                    begin
                        addr_next = second_addr;
                        val_next  = second_val;
                        last_next = 1'b1;
                        done_next = job_reg.frame_end;
                        sel_next  = SEL_LUMA;
                        finishing = 1'b1;
                    end
                    default:
                    begin
                        sel_next = SEL_LUMA;
                    end
                endcase
            end
        end

        // Fetch the next job once the current one has issued its last byte
        load    = (!busy_reg || finishing) && !job_empty;
        job_pop = load;
        if (load)
        begin
            job_next  = job_in;
            busy_next = 1'b1;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= SEL_LUMA;
            ovld_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            sel_reg  <= sel_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        addr_reg <= addr_next;
        val_reg  <= val_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign empty         = !ovld_reg;
    assign byte_address  = addr_reg;
    assign byte_value    = val_reg;
    assign last_of_pixel = last_reg;
    assign frame_done    = done_reg;

    a_idle_at_luma: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> sel_reg == SEL_LUMA)
        else $error("byte selector left mid-pixel without a job");

    a_chroma_only: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != SEL_LUMA) |-> (busy_reg && job_reg.chroma))
        else $error("chroma byte selected for a luma-only pixel");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ovld_reg && done_reg) |-> last_reg)
        else $error("frame end flagged on a byte that does not close its pixel");

endmodule

[design/rgb_to_yuv420_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_packer
// BT.601 RGB to YUV 4:2:0 converter emitting I420/YV12/NV12/NV21 byte writes.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  pixel in | push / full          | red_sample, green_sample, blue_sample
//  bytes out| pop / empty          | byte_address, byte_value, last_of_pixel,
//           |                      | frame_done
//  config   | cfg_we               | cfg_index, cfg_wdata
//
//  One byte transfer per cycle leaves the byte sequencer while pop is held;
//  a pixel gives one byte on odd rows or odd columns and three bytes at its
//  2x2 block's top-left: about two bytes per pixel on even rows, one on odd.
//  A four-entry job queue lets pixel intake run ahead of byte emission.
//  Reset clears the raster counters and restores 640x480 I420.
//  A width, height or layout write restarts the frame at the next pixel.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_packer #(
    parameter int MAX_WIDTH  = r2y420_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = r2y420_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [r2y420_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [r2y420_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [r2y420_pkg::SAMPLE_W-1:0] red_sample,
    input  logic signed [r2y420_pkg::SAMPLE_W-1:0] green_sample,
    input  logic signed [r2y420_pkg::SAMPLE_W-1:0] blue_sample,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [r2y420_pkg::ADDR_W-1:0]          byte_address,
    output logic [r2y420_pkg::BYTE_W-1:0]          byte_value,
    output logic                                   last_of_pixel,
    output logic                                   frame_done
);
    import r2y420_pkg::*;

    localparam int DIMW_W = $clog2(MAX_WIDTH + 1);
    localparam int DIMH_W = $clog2(MAX_HEIGHT + 1);

    logic              restart;
    logic [DIMW_W-1:0] eff_width;
    logic [DIMH_W-1:0] eff_height;
    chroma_cfg_t       chroma_cfg;
    logic              job_push;
    logic              job_full;
    logic              job_pop;
    logic              job_empty;
    job_t              job_wr;
    job_t              job_rd;

    r2y420_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DIMW_W     (DIMW_W),
        .DIMH_W     (DIMH_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .restart    (restart),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .chroma_cfg (chroma_cfg)
    );

    r2y420_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DIMW_W     (DIMW_W),
        .DIMH_W     (DIMH_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .red_sample   (red_sample),
        .green_sample (green_sample),
        .blue_sample  (blue_sample),
        .restart      (restart),
        .eff_width    (eff_width),
        .eff_height   (eff_height),
        .job_push     (job_push),
        .job          (job_wr),
        .job_full     (job_full)
    );

    r2y420_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_wr),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd),
        .empty   (job_empty)
    );

    r2y420_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_in        (job_rd),
        .job_empty     (job_empty),
        .job_pop       (job_pop),
        .chroma_cfg    (chroma_cfg),
        .empty         (empty),
        .pop           (pop),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .last_of_pixel (last_of_pixel),
        .frame_done    (frame_done)
    );

endmodule

[bench/rgb_to_yuv420_packer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_packer_test
// Self-checking bench for the RGB to YUV 4:2:0 packer. A short table walks
// the colour and frame-size extremes, every chroma layout, odd and ignored
// register writes; random frames follow with random gaps on both queue
// sides. Every byte transfer is compared with a BT.601 model kept here.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_packer_test;
    import r2y420_pkg::*;

    localparam int RANDOM_PIXELS = 450;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_SHOWN     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {
        STEP_PIXEL,
        STEP_WRITE
    } step_kind_t;

    typedef struct packed {
        step_kind_t                 kind;
        logic [CFG_IDX_W-1:0]       index;
        logic [CFG_W-1:0]           data;
        logic signed [SAMPLE_W-1:0] red;
        logic signed [SAMPLE_W-1:0] green;
        logic signed [SAMPLE_W-1:0] blue;
        logic                       typed;
        logic [BYTE_W-1:0]          y;
        logic [BYTE_W-1:0]          u;
        logic [BYTE_W-1:0]          v;
    } step_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              done;
    } byte_write_t;

    localparam int PLAN_LEN = 35;
    // Typed bytes: black gives 16/128/128, white gives 235/128/128
    localparam step_t PLAN [PLAN_LEN] = '{
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sh8000, 16'shFFFF, 16'sd0, 1'b1, 8'd16, 8'd128, 8'd128},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sh7FFF, 16'sd256, 16'sd255, 1'b1, 8'd235, 8'd128, 8'd128},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd255, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd0, 16'sd255, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_FRAME_WIDTH, 13'd8191, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd0, 16'sd0, 16'sd255, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd128, 16'sd64, 16'sd200, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_FRAME_HEIGHT, 13'd8191, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_LAYOUT, 13'(LAYOUT_YV12), 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd200, 16'sd100, 16'sd50, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, -16'sd5, 16'sd300, 16'sd17, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_FRAME_WIDTH, 13'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_FRAME_HEIGHT, 13'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_LAYOUT, 13'(LAYOUT_I420), 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd255, 16'sd255, 16'sd255, 1'b1, 8'd235, 8'd128, 8'd128},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd16, 16'sd32, 16'sd64, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd1, 16'sd2, 16'sd4, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd255, 16'sd128, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_LAYOUT, 13'(LAYOUT_NV12), 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd90, 16'sd200, 16'sd30, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 8'd16, 8'd128, 8'd128},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd255, 16'sd0, 16'sd255, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd17, 16'sd170, 16'sd85, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_LAYOUT, 13'(LAYOUT_NV21), 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd250, 16'sd5, 16'sd140, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd60, 16'sd60, 16'sd60, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_SPARE, 13'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd33, 16'sd66, 16'sd99, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd255, 16'sd255, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_FRAME_WIDTH, 13'd7, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_WRITE, CFG_LAYOUT, 13'(LAYOUT_YV12), 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd12, 16'sd240, 16'sd120, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd240, 16'sd12, 16'sd120, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd120, 16'sd120, 16'sd240, 1'b0, 8'd0, 8'd0, 8'd0},
        '{STEP_PIXEL, 2'd0, 13'd0, 16'sd300, -16'sd300, 16'sd128, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_wdata;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] red_sample;
    logic signed [SAMPLE_W-1:0] green_sample;
    logic signed [SAMPLE_W-1:0] blue_sample;
    logic                       empty;
    logic                       pop;
    logic [ADDR_W-1:0]          byte_address;
    logic [BYTE_W-1:0]          byte_value;
    logic                       last_of_pixel;
    logic                       frame_done;

    // Model of the packer's registers and raster position
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    layout_t             layout_reg;
    int unsigned         row_pos;
    int unsigned         col_pos;
    logic [LUMA_W-1:0]   luma_next;
    logic [CHROMA_W-1:0] chroma_next;

    byte_write_t pending_bytes[$];

    int error_count;
    int pixels_sent;
    int directed_pixels;
    int bytes_checked;
    int frames_seen;
    int chroma_by_layout[4];
    int cycle_count;
    bit src_calm;
    bit sink_calm;
    bit hold_req;

    rgb_to_yuv420_packer uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned even_clip(input logic [CFG_W-1:0] raw,
                                              input int unsigned ceiling);
        int unsigned v;
        v = 32'({raw[CFG_W-1:1], 1'b0});
        if (v < 2)
        begin
            v = 2;
        end
        if (v > ceiling)
        begin
            v = ceiling;
        end
        return v;
    endfunction

    function automatic int clip_sample(input logic signed [SAMPLE_W-1:0] s);
        if (s < 0)
        begin
            return 0;
        end
        if (s > 255)
        begin
            return 255;
        end
        return int'(s);
    endfunction

    // Floor shift of the weighted sum, then bias
    function automatic logic [BYTE_W-1:0] bt601_byte(input int acc, input int bias);
        return BYTE_W'((acc >>> 8) + bias);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(16'h8000, 16'hFFFF));
            2: return SAMPLE_W'($urandom_range(256, 32767));
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input int unsigned typical);
        case ($urandom_range(0, 11))
            0: return CFG_W'($urandom);
            1: return CFG_W'($urandom_range(0, 1));
            default: return CFG_W'($urandom_range(2, typical));
        endcase
    endfunction

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        if (error_count < MAX_SHOWN)
        begin
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
        error_count++;
    endtask

    function automatic void restart_raster();
        row_pos     = 0;
        col_pos     = 0;
        luma_next   = '0;
        chroma_next = '0;
    endfunction

    // Queue the byte writes that one pixel causes and advance the raster
    task automatic expect_pixel(input step_t st);
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned first_addr;
        int unsigned second_addr;
        int r;
        int g;
        int b;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] first_val;
        logic [BYTE_W-1:0] second_val;
        bit chroma;
        bit frame_end;
        w    = even_clip(width_reg, DEF_MAX_WIDTH);
        h    = even_clip(height_reg, DEF_MAX_HEIGHT);
        area = w * h;
        r = clip_sample(st.red);
        g = clip_sample(st.green);
        b = clip_sample(st.blue);
        y = bt601_byte(66 * r + 129 * g + 25 * b + 128, 16);
        u = bt601_byte(-38 * r - 74 * g + 112 * b + 128, 128);
        v = bt601_byte(112 * r - 94 * g - 18 * b + 128, 128);
        if (st.typed)
        begin
            y = st.y;
            u = st.u;
            v = st.v;
        end
        chroma    = (row_pos[0] == 1'b0) && (col_pos[0] == 1'b0);
        frame_end = (row_pos + 1 >= h) && (col_pos + 1 >= w);
        pending_bytes.push_back(byte_write_t'{ADDR_W'(luma_next), y, !chroma,
                                              frame_end && !chroma});
        if (chroma)
        begin
            first_val  = u;
            second_val = v;
            case (layout_reg)
                LAYOUT_I420:
                begin
                    first_addr  = area + chroma_next;
                    second_addr = area + area / 4 + chroma_next;
                end
                LAYOUT_YV12:
                begin
                    first_addr  = area + area / 4 + chroma_next;
                    second_addr = area + chroma_next;
                end
                LAYOUT_NV12:
                begin
                    first_addr  = area + 2 * chroma_next;
                    second_addr = first_addr + 1;
                end
                default:
                begin
                    first_addr  = area + 2 * chroma_next;
                    second_addr = first_addr + 1;
                    first_val   = v;
                    second_val  = u;
                end
            endcase
            pending_bytes.push_back(byte_write_t'{ADDR_W'(first_addr), first_val, 1'b0, 1'b0});
            pending_bytes.push_back(byte_write_t'{ADDR_W'(second_addr), second_val, 1'b1,
                                                  frame_end});
            chroma_next = chroma_next + 1'b1;
            chroma_by_layout[layout_reg]++;
        end
        if (frame_end)
        begin
            restart_raster();
            frames_seen++;
        end
        else
        begin
            luma_next = luma_next + 1'b1;
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
        end
    endtask

    task automatic send_pixel(input step_t st);
        int gap;
        if ($urandom_range(0, 29) == 0)
        begin
            src_calm = !src_calm;
        end
        gap = src_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        red_sample   <= st.red;
        green_sample <= st.green;
        blue_sample  <= st.blue;
        // The transfer happens at the first edge that sees full low
        do
        begin
            @(posedge clk);
        end
        while (full);
        expect_pixel(st);
        pixels_sent++;
    endtask

    // Write only once every queued byte has been drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        bit known;
        push <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        known = 1'b1;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg  = data;
            CFG_FRAME_HEIGHT: height_reg = data;
            CFG_LAYOUT:       layout_reg = layout_t'(data[1:0]);
            default:          known = 1'b0;
        endcase
        if (known)
        begin
            restart_raster();
        end
    endtask

    task automatic check_byte();
        byte_write_t want;
        bytes_checked++;
        if (pending_bytes.size() == 0)
        begin
            report_error("byte with nothing pending", 32'(byte_address), 32'hFFFF_FFFF);
            return;
        end
        want = pending_bytes.pop_front();
        if (byte_address !== want.addr)
        begin
            report_error("byte_address", 32'(byte_address), 32'(want.addr));
        end
        if (byte_value !== want.value)
        begin
            report_error("byte_value", 32'(byte_value), 32'(want.value));
        end
        if (last_of_pixel !== want.last)
        begin
            report_error("last_of_pixel", 32'(last_of_pixel), 32'(want.last));
        end
        if (frame_done !== want.done)
        begin
            report_error("frame_done", 32'(frame_done), 32'(want.done));
        end
    endtask

    initial
    begin : byte_sink
        int wait_left;
        int hold_left;
        wait_left = 0;
        hold_left = 0;
        pop       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_byte();
                if ($urandom_range(0, 29) == 0)
                begin
                    sink_calm = !sink_calm;
                end
                wait_left = sink_calm ? 0 : $urandom_range(0, 10);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            // Hold off for a long stretch so the packer fills and stalls intake
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            pop <= (wait_left == 0) && (hold_left == 0);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
                 pending_bytes.size());
        $display("rgb_to_yuv420_packer_test: errors");
        $finish;
    end

    initial
    begin : stimulus
        int random_sent;
        int phase;
        int count;
        int unsigned area;
        step_t st;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        push         = 1'b0;
        red_sample   = '0;
        green_sample = '0;
        blue_sample  = '0;
        width_reg    = RESET_WIDTH;
        height_reg   = RESET_HEIGHT;
        layout_reg   = LAYOUT_I420;
        restart_raster();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == STEP_WRITE)
            begin
                write_reg(PLAN[i].index, PLAN[i].data);
            end
            else
            begin
                send_pixel(PLAN[i]);
            end
        end
        directed_pixels = pixels_sent;

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            if (phase == 0)
            begin
                write_reg(CFG_FRAME_WIDTH, 13'd8);
                write_reg(CFG_FRAME_HEIGHT, 13'd8);
                write_reg(CFG_LAYOUT, CFG_W'($urandom));
                count    = 64;
                hold_req = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    write_reg(CFG_FRAME_WIDTH, pick_size(16));
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    write_reg(CFG_FRAME_HEIGHT, pick_size(8));
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    write_reg(CFG_LAYOUT, CFG_W'($urandom));
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    write_reg(CFG_SPARE, CFG_W'($urandom));
                end
                area = even_clip(width_reg, DEF_MAX_WIDTH) * even_clip(height_reg, DEF_MAX_HEIGHT);
                // Mostly whole frames; large sizes only get a short partial run
                if (area <= 128 && $urandom_range(0, 3) != 0)
                begin
                    count = area * $urandom_range(1, 2);
                end
                else
                begin
                    count = $urandom_range(1, 24);
                end
            end
            if (count > RANDOM_PIXELS - random_sent)
            begin
                count = RANDOM_PIXELS - random_sent;
            end
            repeat (count)
            begin
                st       = '0;
                st.kind  = STEP_PIXEL;
                st.red   = rand_sample();
                st.green = rand_sample();
                st.blue  = rand_sample();
                send_pixel(st);
            end
            random_sent += count;
            phase++;
        end

        push <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("covered %0d pixels (%0d from the table), %0d byte transfers, %0d whole frames",
                 pixels_sent, directed_pixels, bytes_checked, frames_seen);
        $display("chroma samples by layout: I420 %0d, YV12 %0d, NV12 %0d, NV21 %0d",
                 chroma_by_layout[LAYOUT_I420], chroma_by_layout[LAYOUT_YV12],
                 chroma_by_layout[LAYOUT_NV12], chroma_by_layout[LAYOUT_NV21]);
        if (error_count == 0)
        begin
            $display("rgb_to_yuv420_packer_test: clean");
        end
        else
        begin
            $display("rgb_to_yuv420_packer_test: errors");
        end
        $finish;
    end

endmodule

[rgb_to_yuv420_packer.f]
design/r2y420_pkg.sv
design/r2y420_cfg.sv
design/r2y420_front.sv
design/r2y420_fifo.sv
design/r2y420_back.sv
design/rgb_to_yuv420_packer.sv
bench/rgb_to_yuv420_packer_test.sv
